### src/cu_pkg.sv
// cu_pkg: shared types, widths, register codes and table addressing for the
// combination unrank block; no dependencies
package cu_pkg;

   // configuration limits
   localparam int MAX_ITEMS  = 256;
   localparam int MAX_CHOOSE = 8;

   // field widths
   localparam int RANK_W     = 49;
   localparam int SIZE_W     = 9;
   localparam int CHOOSE_W   = 4;
   localparam int ELEM_W     = 8;
   localparam int POS_W      = 3;

   // binomial table: rows m = 0..MAX_ITEMS, columns r = 0..MAX_CHOOSE
   localparam int BINOM_W     = 49;
   localparam int ROW_COUNT   = MAX_ITEMS + 1;
   localparam int COL_COUNT   = MAX_CHOOSE + 1;
   localparam int ROW_W       = $clog2(ROW_COUNT);
   localparam int COL_W       = $clog2(COL_COUNT);
   localparam int TABLE_DEPTH = ROW_COUNT * COL_COUNT;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_SIZE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHOOSE_COUNT = CSR_IDX_W'(1);
   localparam logic [SIZE_W-1:0]    SET_SIZE_RST     = SIZE_W'(4);
   localparam logic [CHOOSE_W-1:0]  CHOOSE_COUNT_RST = CHOOSE_W'(4);

   typedef struct packed {
      logic [BINOM_W-1:0] a;
      logic [BINOM_W-1:0] b;
      logic               sub;
   } alu_req_type;

   typedef struct packed {
      logic [BINOM_W-1:0] res;
      logic               carry;   // carry out on add, borrow on subtract
   } alu_rsp_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [BINOM_W-1:0] data;
   } mem_wr_type;

   // row-major placement of C(m, r)
   function automatic logic [ADDR_W-1:0] binom_addr(input logic [ROW_W-1:0] m,
                                                    input logic [COL_W-1:0] r);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(m) * ADDR_W'(COL_COUNT);
      return base + ADDR_W'(r);
   endfunction

endpackage

### src/cu_alu.sv
// cu_alu: shared add / subtract unit with carry or borrow out
// depends on cu_pkg
module cu_alu (
   input  cu_pkg::alu_req_type alu_req,
   output cu_pkg::alu_rsp_type alu_rsp
);
   import cu_pkg::*;

   logic [BINOM_W:0] wide;

   always_comb begin
      if (alu_req.sub) begin
         wide = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      end else begin
         wide = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      end
      alu_rsp.res   = wide[BINOM_W-1:0];
      alu_rsp.carry = wide[BINOM_W];
   end

endmodule

### src/cu_binom_table.sv
// cu_binom_table: binomial coefficient store, one write port and one
// registered read port; depends on cu_pkg
module cu_binom_table (
   input  logic                       clock,
   input  cu_pkg::mem_wr_type         mem_wr,
   input  logic [cu_pkg::ADDR_W-1:0]  rd_addr,
   output logic [cu_pkg::BINOM_W-1:0] rd_data
);
   import cu_pkg::*;

   logic [BINOM_W-1:0] mem [0:TABLE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### src/cu_fill.sv
// cu_fill: builds the binomial table after reset, one entry a cycle, by
// pascal's rule on the shared adder; depends on cu_pkg
module cu_fill (
   input  logic                clock,
   input  logic                reset,
   input  cu_pkg::alu_rsp_type alu_rsp,
   output cu_pkg::alu_req_type alu_req,
   output cu_pkg::mem_wr_type  mem_wr,
   output logic                fill_done
);
   import cu_pkg::*;

   logic [ROW_W-1:0]   m_ff, m_in;
   logic [COL_W-1:0]   r_ff, r_in;
   logic               done_ff, done_in;
   logic [BINOM_W-1:0] row_ff [0:COL_COUNT-1];   // previous row, updated in place
   logic [BINOM_W-1:0] carry_ff;                 // old row entry at r - 1
   logic [BINOM_W-1:0] value;

   always_comb begin
      alu_req.a   = row_ff[r_ff];
      alu_req.b   = carry_ff;
      alu_req.sub = 1'b0;

      if (r_ff == '0) begin
         value = BINOM_W'(1);
      end else if (m_ff == '0) begin
         value = '0;
      end else begin
         value = alu_rsp.res;
      end

      mem_wr.en   = !done_ff;
      mem_wr.addr = binom_addr(m_ff, r_ff);
      mem_wr.data = value;

      m_in    = m_ff;
      r_in    = r_ff;
      done_in = done_ff;
      if (!done_ff) begin
         if (r_ff == COL_W'(COL_COUNT - 1)) begin
            r_in = '0;
            if (m_ff == ROW_W'(ROW_COUNT - 1)) begin
               done_in = 1'b1;
            end else begin
               m_in = m_ff + ROW_W'(1);
            end
         end else begin
            r_in = r_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff    <= '0;
         r_ff    <= '0;
         done_ff <= 1'b0;
      end else begin
         m_ff    <= m_in;
         r_ff    <= r_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!done_ff) begin
         row_ff[r_ff] <= value;
         carry_ff     <= row_ff[r_ff];
      end
   end

   assign fill_done = done_ff;

endmodule

### src/cu_unrank.sv
// cu_unrank: sequencer that walks candidates, compares and subtracts the
// remaining rank against table entries, and holds the result word
// depends on cu_pkg
module cu_unrank (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fill_done,
   input  logic [cu_pkg::SIZE_W-1:0]   set_size,
   input  logic [cu_pkg::CHOOSE_W-1:0] choose_count,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cu_pkg::RANK_W-1:0]   req_rank,
   output logic [cu_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [cu_pkg::BINOM_W-1:0]  rd_data,
   output cu_pkg::alu_req_type         alu_req,
   input  cu_pkg::alu_rsp_type         alu_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cu_pkg::ELEM_W-1:0]   rsp_element,
   output logic [cu_pkg::POS_W-1:0]    rsp_position,
   output logic                        rsp_last,
   output logic                        rsp_out_of_range
);
   import cu_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CHK_RD   = 3'd1;
   localparam logic [2:0] ST_CHK_CMP  = 3'd2;
   localparam logic [2:0] ST_CAND_RD  = 3'd3;
   localparam logic [2:0] ST_CAND_CMP = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   n_ff, n_in;
   logic [CHOOSE_W-1:0] k_ff, k_in;
   logic [RANK_W-1:0]   rem_ff, rem_in;
   logic [ELEM_W-1:0]   j_ff, j_in;
   logic [POS_W-1:0]    i_ff, i_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_out_of_range_ff, rsp_out_of_range_in;

   logic                accept;
   logic                slot_free;
   logic                load;
   logic                is_last;
   logic                rank_below;
   logic [ROW_W-1:0]    m_cand;
   logic [CHOOSE_W-1:0] r_cand;

   assign req_stall = !((state_ff == ST_IDLE) && fill_done);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = ({1'b0, i_ff} + CHOOSE_W'(1)) == k_ff;

   // borrow out of rem - C means rem is below C
   assign rank_below = alu_rsp.carry;

   assign m_cand = ROW_W'(n_ff) - ROW_W'(j_ff) - ROW_W'(1);
   assign r_cand = k_ff - CHOOSE_W'(i_ff) - CHOOSE_W'(1);

   always_comb begin
      if ((state_ff == ST_CHK_RD) || (state_ff == ST_CHK_CMP)) begin
         rd_addr = binom_addr(ROW_W'(n_ff), COL_W'(k_ff));
      end else begin
         rd_addr = binom_addr(m_cand, COL_W'(r_cand));
      end
      alu_req.a   = BINOM_W'(rem_ff);
      alu_req.b   = rd_data;
      alu_req.sub = 1'b1;
   end

   always_comb begin
      state_in            = state_ff;
      n_in                = n_ff;
      k_in                = k_ff;
      rem_in              = rem_ff;
      j_in                = j_ff;
      i_in                = i_ff;
      load                = 1'b0;
      rsp_element_in      = rsp_element_ff;
      rsp_position_in     = rsp_position_ff;
      rsp_last_in         = rsp_last_ff;
      rsp_out_of_range_in = rsp_out_of_range_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = set_size;
               k_in     = choose_count;
               rem_in   = req_rank;
               j_in     = '0;
               i_in     = '0;
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_CMP;
         end
         ST_CHK_CMP: begin
            // empty choice reads C(n, 0) = 1, so it is flagged on its own
            if ((k_ff == '0) || !rank_below) begin
               if (slot_free) begin
                  load                = 1'b1;
                  rsp_element_in      = '0;
                  rsp_position_in     = '0;
                  rsp_last_in         = 1'b1;
                  rsp_out_of_range_in = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else begin
               state_in = ST_CAND_RD;
            end
         end
         ST_CAND_RD: begin
            state_in = ST_CAND_CMP;
         end
         ST_CAND_CMP: begin
            if (rank_below) begin
               if (slot_free) begin
                  load                = 1'b1;
                  rsp_element_in      = j_ff;
                  rsp_position_in     = i_ff;
                  rsp_last_in         = is_last;
                  rsp_out_of_range_in = 1'b0;
                  if (is_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + POS_W'(1);
                     j_in     = j_ff + ELEM_W'(1);
                     state_in = ST_CAND_RD;
                  end
               end
            end else begin
               rem_in   = RANK_W'(alu_rsp.res);
               j_in     = j_ff + ELEM_W'(1);
               state_in = ST_CAND_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff                <= n_in;
      k_ff                <= k_in;
      rem_ff              <= rem_in;
      j_ff                <= j_in;
      i_ff                <= i_in;
      rsp_element_ff      <= rsp_element_in;
      rsp_position_ff     <= rsp_position_in;
      rsp_last_ff         <= rsp_last_in;
      rsp_out_of_range_ff <= rsp_out_of_range_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element      = rsp_element_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

endmodule

### src/combination_unrank_top.sv
// combination_unrank_top: lexicographic k-subset unranking, top level
// depends on cu_pkg, cu_alu, cu_binom_table, cu_fill, cu_unrank
//
// csr: csr_index picks set_size (n) or choose_count (k), taken whenever
//   csr_valid is high (csr_ready tied high); write only while the block is
//   idle. n saturates at 256 and k at 8 when used
// req: one rank word per combination, taken on req_valid with req_stall low
// rsp: k words per rank, elements ascending, position from 0, last on the
//   final one; a rank not below C(n,k), k of 0 or k > n give one word with
//   out_of_range and last set, element and position 0
// reset: clears the control state, loads n = 4, k = 4, then sweeps the
//   binomial table, 257 rows x 9 columns = 2313 entries, with req_stall high
// timing: a rank is taken in idle, then the range check and a visit per
//   candidate (table read, then subtract on the shared adder); the last
//   word is registered at the end of the walk and the next rank can go in
//   the cycle after, one rank at a time
// stalls: results sit in an output register; the walk only waits when a new
//   word is due while that register is still held by rsp_stall
module combination_unrank_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cu_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cu_pkg::RANK_W-1:0]     req_rank,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cu_pkg::ELEM_W-1:0]     rsp_element,
   output logic [cu_pkg::POS_W-1:0]      rsp_position,
   output logic                          rsp_last,
   output logic                          rsp_out_of_range
);
   import cu_pkg::*;

   // configuration registers, raw as written
   logic [SIZE_W-1:0]   set_size_ff, set_size_in;
   logic [CHOOSE_W-1:0] choose_count_ff, choose_count_in;

   // saturated copies that the walk uses
   logic [SIZE_W-1:0]   set_size_sat;
   logic [CHOOSE_W-1:0] choose_count_sat;

   logic                fill_done;
   alu_req_type         fill_alu_req;
   alu_req_type         walk_alu_req;
   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;
   mem_wr_type          mem_wr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BINOM_W-1:0]  rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      set_size_in     = set_size_ff;
      choose_count_in = choose_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_SIZE: begin
               set_size_in = csr_wdata[SIZE_W-1:0];
            end
            CSR_CHOOSE_COUNT: begin
               choose_count_in = csr_wdata[CHOOSE_W-1:0];
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= SET_SIZE_RST;
         choose_count_ff <= CHOOSE_COUNT_RST;
      end else begin
         set_size_ff     <= set_size_in;
         choose_count_ff <= choose_count_in;
      end
   end

   always_comb begin
      if (set_size_ff > SIZE_W'(MAX_ITEMS)) begin
         set_size_sat = SIZE_W'(MAX_ITEMS);
      end else begin
         set_size_sat = set_size_ff;
      end
      if (choose_count_ff > CHOOSE_W'(MAX_CHOOSE)) begin
         choose_count_sat = CHOOSE_W'(MAX_CHOOSE);
      end else begin
         choose_count_sat = choose_count_ff;
      end
   end

   // the adder belongs to the table sweep until it finishes, then to the walk
   assign alu_req = fill_done ? walk_alu_req : fill_alu_req;

   cu_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   cu_fill u_fill (
      .clock     (clock),
      .reset     (reset),
      .alu_rsp   (alu_rsp),
      .alu_req   (fill_alu_req),
      .mem_wr    (mem_wr),
      .fill_done (fill_done)
   );

   cu_binom_table u_table (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cu_unrank u_unrank (
      .clock            (clock),
      .reset            (reset),
      .fill_done        (fill_done),
      .set_size         (set_size_sat),
      .choose_count     (choose_count_sat),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rank         (req_rank),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .alu_req          (walk_alu_req),
      .alu_rsp          (alu_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element      (rsp_element),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

### src/cu_checker.sv
// cu_checker: port-level checks on combination_unrank_top, and its bind
// depends on cu_pkg
module cu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [cu_pkg::ELEM_W-1:0]     rsp_element,
   input logic [cu_pkg::POS_W-1:0]      rsp_position,
   input logic                          rsp_last,
   input logic                          rsp_out_of_range
);
   import cu_pkg::*;

   // a held result word keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element) &&
         $stable(rsp_position) && $stable(rsp_last) && $stable(rsp_out_of_range))
      else $error("result word changed while stalled");

   // the walk leaves idle on a take, so the input closes right after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open in the cycle after a rank was taken");

   // the table sweep keeps the input closed straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input open before the table sweep");

   // an error word stands alone and carries no element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_last && (rsp_element == '0) && (rsp_position == '0))
      else $error("malformed out-of-range word");

endmodule

bind combination_unrank_top cu_checker u_checker (.*);
